/* hw/rtl/bad_pkg.sv */
// shared types and constants for the bounded array deque
`timescale 1ns / 1ps

package bad_pkg;

  // default geometry
  localparam int unsigned DepthDefault     = 64;
  localparam int unsigned DataWidthDefault = 32;

  // fixed field widths of the ports
  localparam int unsigned WordW = 32;
  localparam int unsigned CapW  = 7;

  // capacity register after reset
  localparam logic [CapW-1:0] CapReset = 7'd64;

  // operation codes carried on func_i
  typedef enum logic [1:0] {
    FuncPushFront = 2'd0,
    FuncPushBack  = 2'd1,
    FuncPopFront  = 2'd2,
    FuncPopBack   = 2'd3
  } func_e;

endpackage

/* hw/rtl/bad_ring_ram.sv */
// ring storage: one write port, two registered read ports
`timescale 1ns / 1ps

module bad_ring_ram #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_a_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]         raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, old data on a same-cycle collision
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* hw/rtl/bounded_array_deque.sv */
// top level of the bounded array deque
`timescale 1ns / 1ps

// Bounded double-ended queue of words held in a ring memory.
// Command channel: func_i and data_value_i are taken at a rising edge with
// start_i high and busy_o low. busy_o stays low, so a command may be issued
// in every cycle; one command per cycle is the sustained throughput.
// Each command gives one result in the next cycle: done_o is high for exactly
// that cycle together with op_ok_o, front_value_o, back_value_o and
// entry_total_o. The receiver cannot stall; a result shows for one cycle only.
// Pointers and count update at the accepting edge, the push word is written
// into the ring at the same edge and the new front and back slots are read
// through the two registered read ports; a read of the slot being written is
// served from a bypass register.
// Config channel: cfg_data_i is the capacity limit, written at an edge with
// cfg_valid_i and cfg_ready_o high; write it only while no command is in
// flight. Capacity above DEPTH acts as DEPTH, zero refuses every push.
// Reset (rst_ni low, asynchronous) empties the queue and sets the capacity
// to 64; the ring contents are not cleared and need no clearing pass.
module bounded_array_deque
  import bad_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   func_i,
  input  logic [WordW-1:0]             data_value_i,
  output logic                         done_o,
  output logic                         op_ok_o,
  output logic [WordW-1:0]             front_value_o,
  output logic [WordW-1:0]             back_value_o,
  output logic [$clog2(DEPTH+1)-1:0]   entry_total_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CapW-1:0]              cfg_data_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MW   = (CW > CapW) ? CW : CapW;
  localparam int unsigned XW   = (DATA_WIDTH > WordW) ? DATA_WIDTH : WordW;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [MW-1:0] DepthM  = MW'(DEPTH);

  logic [AW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CapW-1:0]       cap_q;
  logic                  done_q, ok_q, ok_d;
  logic                  fwd_front_q, fwd_back_q;
  logic [DATA_WIDTH-1:0] word_q;

  logic                  accept;
  logic                  can_push, can_pop;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr_front, raddr_back;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rd_front, rd_back;
  logic [DATA_WIDTH-1:0] sel_front, sel_back;
  logic [XW-1:0]         wide_in, wide_front, wide_back;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : AW'(i + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LastIdx : AW'(i - 1'b1);
  endfunction

  // one command per cycle, config always taken
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // word trimmed to the stored width
  assign wide_in = XW'(data_value_i);
  assign wdata   = wide_in[DATA_WIDTH-1:0];

  // full and empty checks
  assign can_push = (MW'(count_q) < MW'(cap_q)) && (MW'(count_q) < DepthM);
  assign can_pop  = (count_q != '0);

  // pointer, count and write port update
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    ok_d = 1'b0;
    we = 1'b0;
    waddr = tail_q;
    if (accept) begin
      case (func_e'(func_i))
        FuncPushFront: begin
          if (can_push) begin
            head_d = ring_prev(head_q);
            waddr = ring_prev(head_q);
            we = 1'b1;
            count_d = CW'(count_q + 1'b1);
            ok_d = 1'b1;
          end
        end
        FuncPushBack: begin
          if (can_push) begin
            tail_d = ring_next(tail_q);
            waddr = tail_q;
            we = 1'b1;
            count_d = CW'(count_q + 1'b1);
            ok_d = 1'b1;
          end
        end
        FuncPopFront: begin
          if (can_pop) begin
            head_d = ring_next(head_q);
            count_d = CW'(count_q - 1'b1);
            ok_d = 1'b1;
          end
        end
        FuncPopBack: begin
          if (can_pop) begin
            tail_d = ring_prev(tail_q);
            count_d = CW'(count_q - 1'b1);
            ok_d = 1'b1;
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  // slots of the new front and back
  assign raddr_front = head_d;
  assign raddr_back  = ring_prev(tail_d);

  bad_ring_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_front),
    .rdata_a_o (rd_front),
    .raddr_b_i (raddr_back),
    .rdata_b_o (rd_back)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= CapReset;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // result flag and bypass of a same-slot write
  always_ff @(posedge clk_i) begin
    ok_q        <= ok_d;
    fwd_front_q <= we && (waddr == raddr_front);
    fwd_back_q  <= we && (waddr == raddr_back);
    word_q      <= wdata;
  end

  // result formatting, zero words when empty
  assign sel_front  = fwd_front_q ? word_q : rd_front;
  assign sel_back   = fwd_back_q ? word_q : rd_back;
  assign wide_front = XW'(sel_front);
  assign wide_back  = XW'(sel_back);

  assign done_o        = done_q;
  assign op_ok_o       = ok_q;
  assign entry_total_o = count_q;
  assign front_value_o = (count_q == '0) ? '0 : wide_front[WordW-1:0];
  assign back_value_o  = (count_q == '0) ? '0 : wide_back[WordW-1:0];

  // ring consistency: head plus count lands on tail
  logic [AW:0] head_plus_count;
  logic [AW:0] head_count_sum;
  assign head_count_sum  = (AW+1)'(head_q) + (AW+1)'(count_q);
  assign head_plus_count = (head_count_sum >= (AW+1)'(DEPTH)) ?
                           (AW+1)'(head_count_sum - (AW+1)'(DEPTH)) : head_count_sum;

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without a command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(count_q) <= DepthM)
    else $error("entry count above depth");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_plus_count[AW-1:0] == tail_q)
    else $error("head, tail and count disagree");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ok_d) |=> (count_q == $past(count_q)))
    else $error("refused command changed the count");

endmodule
